>>> hw/rtl/bdq_pkg.sv
// Package for the bounded double-ended queue.
// Holds field widths, command codes, reset values and defaults.
// Depends on nothing.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int LIMIT_W       = 11;
    localparam int DEPTH_DEFAULT = 1024;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
    localparam logic [DATA_W-1:0]  EMPTY_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_t;

endpackage

>>> hw/rtl/bdq_if.sv
// Valid/ready channel interfaces for the command and result streams.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

interface bdq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [bdq_pkg::CMD_W-1:0]            command;
    logic signed [bdq_pkg::DATA_W-1:0]    push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface bdq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 accepted;
    logic signed [bdq_pkg::DATA_W-1:0]    front_value;
    logic signed [bdq_pkg::DATA_W-1:0]    rear_value;
    logic                                 is_empty;
    logic                                 is_full;

    modport source (output valid, output accepted, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input accepted, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

>>> hw/rtl/bdq_mem.sv
// Entry store: one write port and two registered read ports.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_mem #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
    parameter int PW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [PW-1:0]               waddr,
    input  logic [bdq_pkg::DATA_W-1:0]  wdata,
    input  logic                        re,
    input  logic [PW-1:0]               raddr_front,
    input  logic [PW-1:0]               raddr_rear,
    output logic [bdq_pkg::DATA_W-1:0]  rdata_front,
    output logic [bdq_pkg::DATA_W-1:0]  rdata_rear
);

    logic [bdq_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_front <= mem[raddr_front];
            rdata_rear  <= mem[raddr_rear];
        end
    end

endmodule

>>> hw/rtl/bdq_ctrl.sv
// Sequencer for the queue: pointers, count, limit register and result register.
// Depends on bdq_pkg and the channel interfaces; drives bdq_mem.
`timescale 1ns / 1ps

module bdq_ctrl #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
    parameter int PW    = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bdq_in_if.sink                             in_ch,
    bdq_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [bdq_pkg::LIMIT_W-1:0]        cfg_wdata,
    output logic                               mem_we,
    output logic [PW-1:0]                      mem_waddr,
    output logic [bdq_pkg::DATA_W-1:0]         mem_wdata,
    output logic                               mem_re,
    output logic [PW-1:0]                      mem_raddr_front,
    output logic [PW-1:0]                      mem_raddr_rear,
    input  logic [bdq_pkg::DATA_W-1:0]         mem_rdata_front,
    input  logic [bdq_pkg::DATA_W-1:0]         mem_rdata_rear
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > bdq_pkg::LIMIT_W) ? CW : bdq_pkg::LIMIT_W;
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP
    } state_t;

    state_t                       state_reg, state_next;
    logic [PW-1:0]                front_reg, front_next;
    logic [PW-1:0]                rear_reg, rear_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [bdq_pkg::LIMIT_W-1:0]  limit_reg;
    logic                         ok_reg, ok_next;
    logic                         empty_reg, empty_next;
    logic                         full_reg, full_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_ok_reg;
    logic [bdq_pkg::DATA_W-1:0]   out_front_reg, out_rear_reg;
    logic                         out_empty_reg, out_full_reg;

    logic [LW-1:0]                eff_limit;
    logic                         full_now;
    logic                         empty_now;
    logic                         accept;
    logic                         load_out;

    function automatic logic [PW-1:0] prev_idx(input logic [PW-1:0] i);
        prev_idx = (i == '0) ? LAST_IDX : i - PW'(1);
    endfunction

    function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] i);
        next_idx = (i == LAST_IDX) ? '0 : i + PW'(1);
    endfunction

    always_comb
    begin
        eff_limit = LW'(limit_reg);
        if (limit_reg == '0)
        begin
            eff_limit = LW'(1);
        end
        else if (eff_limit > LW'(DEPTH))
        begin
            eff_limit = LW'(DEPTH);
        end
    end

    assign full_now  = LW'(count_reg) >= eff_limit;
    assign empty_now = count_reg == '0;
    assign accept    = in_ch.valid && in_ch.ready;
    assign load_out  = (state_reg == ST_RESP) && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        rear_next      = rear_reg;
        count_next     = count_reg;
        ok_next        = ok_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = front_reg;
        mem_wdata      = in_ch.push_value;
        mem_re         = 1'b0;
        mem_raddr_front = front_reg;
        mem_raddr_rear  = prev_idx(rear_reg);

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ok_next = 1'b0;
                    case (in_ch.command)
                        bdq_pkg::CMD_PUSH_FRONT:
                        begin
                            if (!full_now)
                            begin
                                front_next = prev_idx(front_reg);
                                mem_we     = 1'b1;
                                mem_waddr  = prev_idx(front_reg);
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        bdq_pkg::CMD_PUSH_REAR:
                        begin
                            if (!full_now)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = rear_reg;
                                rear_next  = next_idx(rear_reg);
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        bdq_pkg::CMD_POP_FRONT:
                        begin
                            if (!empty_now)
                            begin
                                front_next = next_idx(front_reg);
                                count_next = count_reg - CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        bdq_pkg::CMD_POP_REAR:
                        begin
                            if (!empty_now)
                            begin
                                rear_next  = prev_idx(rear_reg);
                                count_next = count_reg - CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        bdq_pkg::CMD_QUERY:
                        begin
                            ok_next = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                    empty_next = count_next == '0;
                    full_next  = LW'(count_next) >= eff_limit;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            limit_reg     <= bdq_pkg::LIMIT_RESET;
            ok_reg        <= 1'b0;
            empty_reg     <= 1'b1;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_front_reg <= bdq_pkg::EMPTY_VALUE;
            out_rear_reg  <= bdq_pkg::EMPTY_VALUE;
            out_empty_reg <= 1'b1;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            count_reg     <= count_next;
            ok_reg        <= ok_next;
            empty_reg     <= empty_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                out_ok_reg    <= ok_reg;
                out_front_reg <= empty_reg ? bdq_pkg::EMPTY_VALUE : mem_rdata_front;
                out_rear_reg  <= empty_reg ? bdq_pkg::EMPTY_VALUE : mem_rdata_rear;
                out_empty_reg <= empty_reg;
                out_full_reg  <= full_reg;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.accepted    = out_ok_reg;
    assign out_ch.front_value = out_front_reg;
    assign out_ch.rear_value  = out_rear_reg;
    assign out_ch.is_empty    = out_empty_reg;
    assign out_ch.is_full     = out_full_reg;

endmodule

>>> hw/rtl/bounded_double_ended_queue_top.sv
// Top level of the bounded double-ended queue: sequencer plus entry store.
// Depends on bdq_pkg, the channel interfaces, bdq_ctrl and bdq_mem.
//
// Channel   Direction  Payload                                          Transfer when
// in_ch     in         command[2:0], push_value[31:0]                   valid && ready
// out_ch    out        accepted, front_value, rear_value, is_empty,     valid && ready
//                      is_full
// cfg       in         cfg_wdata[10:0] (capacity limit)                 cfg_we
//
// Each command passes through the sequencer states in order: in idle the transfer updates
// pointers and writes the entry store, in read the front and rear entries are read, and
// in respond the result register is loaded; the registered read ports need the read state.
// A new command is taken while the previous result still waits in the result register;
// a stalled output holds the sequencer in its last step. Reset is immediate, with no
// clearing pass over the entry store.
`timescale 1ns / 1ps

module bounded_double_ended_queue_top #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bdq_in_if.sink                       in_ch,
    bdq_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [bdq_pkg::LIMIT_W-1:0]  cfg_wdata
);

    localparam int PW = $clog2(DEPTH);

    logic                        mem_we;
    logic [PW-1:0]               mem_waddr;
    logic [bdq_pkg::DATA_W-1:0]  mem_wdata;
    logic                        mem_re;
    logic [PW-1:0]               mem_raddr_front;
    logic [PW-1:0]               mem_raddr_rear;
    logic [bdq_pkg::DATA_W-1:0]  mem_rdata_front;
    logic [bdq_pkg::DATA_W-1:0]  mem_rdata_rear;

    bdq_ctrl #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr_front (mem_raddr_front),
        .mem_raddr_rear  (mem_raddr_rear),
        .mem_rdata_front (mem_rdata_front),
        .mem_rdata_rear  (mem_rdata_rear)
    );

    bdq_mem #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_mem (
        .clk         (clk),
        .we          (mem_we),
        .waddr       (mem_waddr),
        .wdata       (mem_wdata),
        .re          (mem_re),
        .raddr_front (mem_raddr_front),
        .raddr_rear  (mem_raddr_rear),
        .rdata_front (mem_rdata_front),
        .rdata_rear  (mem_rdata_rear)
    );

endmodule

>>> tb/bounded_double_ended_queue_top_tb.sv
// Self-checking testbench for the bounded double-ended queue top level.
// Predicts every result from its own copy of the queue state and checks each output transfer.
// Depends on bdq_pkg, the channel interfaces and bounded_double_ended_queue_top.
`timescale 1ns / 1ps

module bounded_double_ended_queue_top_tb;
    import bdq_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int PW         = $clog2(DEPTH);
    localparam int LONG_HOLD  = 300;
    localparam int IDLE_LIMIT = 3000;

    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] push_value;
    } deque_op_t;

    typedef struct {
        logic              accepted;
        logic [DATA_W-1:0] front_value;
        logic [DATA_W-1:0] rear_value;
        logic              is_empty;
        logic              is_full;
    } deque_report_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    bdq_in_if  in_ch ();
    bdq_out_if out_ch ();

    bounded_double_ended_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    deque_op_t     op_queue[$];
    deque_report_t expected_reports[$];

    logic [DATA_W-1:0]  slot_mem [DEPTH];
    logic [PW-1:0]      head_idx;
    logic [PW-1:0]      tail_idx;
    int unsigned        fill_count;
    logic [LIMIT_W-1:0] cap_reg;

    int err_count;
    int idle_cycles;
    int gap_left;
    int stall_left;
    int hold_left;
    int hold_requests;
    int hold_served;
    bit no_gap;
    bit in_taken;

    function automatic int unsigned cap_effective();
        if (cap_reg == '0)
            return 1;
        if (int'(cap_reg) > DEPTH)
            return DEPTH;
        return int'(cap_reg);
    endfunction

    function automatic deque_report_t apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [DATA_W-1:0] val);
        deque_report_t r;
        bit            was_full;
        bit            was_empty;
        was_full   = fill_count >= cap_effective();
        was_empty  = fill_count == 0;
        r.accepted = 1'b0;
        case (cmd)
            CMD_PUSH_FRONT:
                if (!was_full)
                begin
                    head_idx = (head_idx == '0) ? LAST_SLOT : head_idx - PW'(1);
                    slot_mem[head_idx] = val;
                    fill_count++;
                    r.accepted = 1'b1;
                end
            CMD_PUSH_REAR:
                if (!was_full)
                begin
                    slot_mem[tail_idx] = val;
                    tail_idx = (tail_idx == LAST_SLOT) ? '0 : tail_idx + PW'(1);
                    fill_count++;
                    r.accepted = 1'b1;
                end
            CMD_POP_FRONT:
                if (!was_empty)
                begin
                    head_idx = (head_idx == LAST_SLOT) ? '0 : head_idx + PW'(1);
                    fill_count--;
                    r.accepted = 1'b1;
                end
            CMD_POP_REAR:
                if (!was_empty)
                begin
                    tail_idx = (tail_idx == '0) ? LAST_SLOT : tail_idx - PW'(1);
                    fill_count--;
                    r.accepted = 1'b1;
                end
            CMD_QUERY:
                r.accepted = 1'b1;
            default:
                r.accepted = 1'b0;
        endcase
        r.is_empty    = fill_count == 0;
        r.is_full     = fill_count >= cap_effective();
        r.front_value = r.is_empty ? EMPTY_VALUE : slot_mem[head_idx];
        r.rear_value  = r.is_empty ? EMPTY_VALUE
                                   : slot_mem[(tail_idx == '0) ? LAST_SLOT
                                                               : tail_idx - PW'(1)];
        return r;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_op(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
        deque_op_t op;
        op.command    = cmd;
        op.push_value = val;
        op_queue.push_back(op);
    endtask

    task automatic add_random(input int n_items, input int push_pct, input int pop_pct);
        int r;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                add_op($urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, draw_value());
            else if (r < push_pct + pop_pct)
                add_op($urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT, draw_value());
            else if (r < 96)
                add_op(CMD_QUERY, draw_value());
            else if (r < 97)
                add_op(CMD_RSVD5, draw_value());
            else if (r < 98)
                add_op(CMD_RSVD6, draw_value());
            else
                add_op(CMD_RSVD7, draw_value());
        end
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] limit);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        while (op_queue.size() != 0 || in_ch.valid || expected_reports.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        deque_op_t op;
        if (!(in_ch.valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (op_queue.size() != 0)
            begin
                op = op_queue.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.command    <= op.command;
                in_ch.push_value <= op.push_value;
                gap_left = no_gap ? 0 : draw_gap();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!no_gap && $urandom_range(0, 99) < 30)
        begin
            stall_left = draw_gap();
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        deque_report_t want;
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result transfer with no expected result pending");
                    err_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (out_ch.accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0d, actual %0d",
                               want.accepted, out_ch.accepted);
                        err_count++;
                    end
                    if (out_ch.front_value !== want.front_value)
                    begin
                        $error("front_value: expected %h, actual %h",
                               want.front_value, out_ch.front_value);
                        err_count++;
                    end
                    if (out_ch.rear_value !== want.rear_value)
                    begin
                        $error("rear_value: expected %h, actual %h",
                               want.rear_value, out_ch.rear_value);
                        err_count++;
                    end
                    if (out_ch.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, actual %0d",
                               want.is_empty, out_ch.is_empty);
                        err_count++;
                    end
                    if (out_ch.is_full !== want.is_full)
                    begin
                        $error("is_full: expected %0d, actual %0d",
                               want.is_full, out_ch.is_full);
                        err_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_reports.push_back(apply_command(in_ch.command, in_ch.push_value));
            if (cfg_we)
                cap_reg = cfg_wdata;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("bounded_double_ended_queue_top verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.command    = CMD_QUERY;
        in_ch.push_value = '0;
        out_ch.ready     = 1'b0;
        head_idx         = '0;
        tail_idx         = '0;
        fill_count       = 0;
        cap_reg          = LIMIT_RESET;
        err_count        = 0;
        idle_cycles      = 0;
        gap_left         = 0;
        stall_left       = 0;
        hold_left        = 0;
        hold_requests    = 0;
        hold_served      = 0;
        no_gap           = 1'b0;
        in_taken         = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Refusals on an empty queue, extreme values at both ends, unknown commands.
        add_op(CMD_QUERY, '0);
        add_op(CMD_POP_FRONT, '0);
        add_op(CMD_POP_REAR, '1);
        add_op(CMD_PUSH_FRONT, 32'h8000_0000);
        add_op(CMD_PUSH_REAR, 32'h7FFF_FFFF);
        add_op(CMD_PUSH_FRONT, '0);
        add_op(CMD_PUSH_REAR, '1);
        add_op(CMD_QUERY, 32'h1357_9BDF);
        add_op(CMD_RSVD5, 32'hDEAD_BEEF);
        add_op(CMD_RSVD6, '0);
        add_op(CMD_RSVD7, '1);
        add_op(CMD_POP_REAR, '0);
        add_op(CMD_POP_FRONT, '0);
        add_op(CMD_POP_REAR, '0);
        add_op(CMD_POP_FRONT, '0);
        add_op(CMD_POP_FRONT, '0);
        drain();

        // A limit of zero behaves as one.
        write_limit('0);
        add_op(CMD_PUSH_REAR, 32'h5555_5555);
        add_op(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        add_op(CMD_PUSH_REAR, 32'hAAAA_AAAA);
        add_op(CMD_POP_FRONT, '0);
        add_op(CMD_POP_REAR, '0);
        drain();

        // A limit above the depth saturates.
        write_limit('1);
        add_op(CMD_PUSH_FRONT, 32'h1234_5678);
        add_op(CMD_QUERY, '0);
        add_op(CMD_POP_REAR, '0);
        drain();

        write_limit(11'd1);
        add_random(40, 45, 40);
        drain();

        write_limit(11'd4);
        add_random(80, 50, 40);
        drain();

        write_limit(11'd16);
        add_random(100, 65, 25);
        drain();

        // The limit drops below the number of entries held.
        write_limit(11'd3);
        add_random(40, 35, 55);
        drain();

        // Back-to-back offers while the receiver holds off, so the input stalls.
        write_limit(LIMIT_RESET);
        no_gap = 1'b1;
        hold_requests++;
        add_random(150, 60, 30);
        drain();
        no_gap = 1'b0;

        write_limit(11'd2);
        add_random(60, 45, 45);
        drain();

        write_limit(11'd7);
        add_random(60, 50, 40);
        drain();

        if (err_count == 0)
            $display("bounded_double_ended_queue_top verification clean");
        else
            $display("bounded_double_ended_queue_top verification failed");
        $finish;
    end

endmodule

>>> bounded_double_ended_queue_top.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_if.sv
hw/rtl/bdq_mem.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bounded_double_ended_queue_top.sv
tb/bounded_double_ended_queue_top_tb.sv
